// ----- hw/rtl/ias_pkg.sv -----
// ============================================================================
// ias_pkg: shared types and constants for the icon animation sequencer
// Field layout of the stream payloads, storage geometry, the sequence word
// codes and the command and status bundles between controller and datapath.
// ============================================================================
package ias_pkg;

  // Storage geometry.
  localparam int ICON_COUNT = 64;
  localparam int SEQ_LENGTH = 64;

  localparam int ICON_AW  = (ICON_COUNT > 1) ? $clog2(ICON_COUNT) : 1;
  localparam int POS_AW   = $clog2(SEQ_LENGTH);
  localparam int WADDR_W  = ICON_AW + POS_AW;

  // Field widths.
  localparam int ACTION_W = 2;
  localparam int ICON_W   = 6;
  localparam int ENTRY_W  = 6;
  localparam int WORD_W   = 16;
  localparam int DELAY_W  = 8;
  localparam int PAL_W    = 3;
  localparam int BMP_W    = 3;
  localparam int FLIP_W   = 2;

  // Input tdata: icon, entry, entry_word from bit 0 up, padded to bytes.
  localparam int ICON_LSB    = 0;
  localparam int ENTRY_LSB   = ICON_LSB + ICON_W;
  localparam int WORD_LSB    = ENTRY_LSB + ENTRY_W;
  localparam int IN_FIELDS_W = WORD_LSB + WORD_W;
  localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;

  // Output tdata: palette_index, bitmap_index, flip_mode from bit 0 up.
  localparam int OUT_FIELDS_W = PAL_W + BMP_W + FLIP_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  // Bit positions inside a sequence word.
  localparam int SW_BMP_LSB = 8;
  localparam int SW_PAL_LSB = 11;
  localparam int SW_FLIPH   = 14;
  localparam int SW_FLIPV   = 15;

  // Action codes carried on in_tuser.
  localparam logic [ACTION_W-1:0] ACT_TICK  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_LOAD  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd2;

  // Sequence word codes.
  localparam logic [WORD_W-1:0] WORD_STATIC      = 16'h0001;
  localparam logic [WORD_W-1:0] WORD_STATIC_NEXT = 16'h0100;
  localparam logic [WORD_W-1:0] DELAY_MASK       = 16'h00FF;
  localparam logic [WORD_W-1:0] WORD_END         = 16'h0000;

  localparam logic [DELAY_W-1:0] DELAY_MAX = '1;
  localparam logic [POS_AW:0]    SEQ_LEN_V = (POS_AW + 1)'(SEQ_LENGTH);

  typedef logic [ICON_AW-1:0] icon_idx_t;
  typedef logic [POS_AW-1:0]  pos_t;
  typedef logic [WADDR_W-1:0] waddr_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic init_step;   // one step of the clearing pass after reset
    logic capture;     // take the request into the item registers
    logic load_wr;     // write one sequence word, rewind the position
    logic clear_step;  // zero one word of the addressed icon
    logic lat_state;   // position and delay count are on the read port
    logic lat_cur;     // current word is on the read port
    logic finish;      // next word is on the read port: update, emit
  } ias_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic init_last;
    logic clear_last;
    logic icon_ok;
    logic entry_ok;
    logic out_busy;
  } ias_sts_t;

  // Icon number to memory row index, extended or truncated as needed.
  function automatic icon_idx_t icon_index(input logic [ICON_W-1:0] icon);
    logic [ICON_AW+ICON_W-1:0] wide;
    wide = {{ICON_AW{1'b0}}, icon};
    return wide[ICON_AW-1:0];
  endfunction

  // Entry number to word position, extended or truncated as needed.
  function automatic pos_t entry_pos(input logic [ENTRY_W-1:0] entry);
    logic [POS_AW+ENTRY_W-1:0] wide;
    wide = {{POS_AW{1'b0}}, entry};
    return wide[POS_AW-1:0];
  endfunction

endpackage

// ----- hw/rtl/icon_animation_sequencer_unit.sv -----
// ============================================================================
// icon_animation_sequencer_unit: per-icon animation sequence player
// Stores an animation sequence for every icon, plays it one frame per tick
// request and reports the palette, bitmap and flip of the current frame.
// ============================================================================
//
//  Channel  Direction  Handshake           Payload
//  -------  ---------  ------------------  ----------------------------------
//  in_      slave      in_tvalid/tready    tuser: action; tdata: icon, entry,
//                                          entry_word
//  out_     master     out_tvalid/tready   tdata: palette_index,
//                                          bitmap_index, flip_mode
//
// A tick request is captured at acceptance; its position and delay count are
// latched, then its current word, and once the next word is on the read port
// the result goes into the output register and the next request can be
// taken. A tick waits in its last read state while the output register holds
// a result that has not been taken yet. A load writes its word when icon and
// entry are in range, and an icon clear zeroes the icon's words, one word per
// cycle. An unused action is taken and dropped. This order is set by the
// single read port of the sequence word memory, which must deliver the
// current and the next word one after the other. After reset the block
// zeroes the word, position and delay memories and accepts no request during
// that pass. One request is handled at a time, and a pending result sits in
// the output register while the next request is taken.
//
module icon_animation_sequencer_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  // Request channel.
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [ias_pkg::IN_TDATA_W-1:0]  in_tdata,   // icon, entry, entry_word
  input  logic [ias_pkg::ACTION_W-1:0]    in_tuser,   // action
  // Result channel.
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [ias_pkg::OUT_TDATA_W-1:0] out_tdata   // palette_index,
                                                      // bitmap_index, flip_mode
);
  import ias_pkg::*;

  ias_cmd_t cmd;
  ias_sts_t sts;

  // The controller sequences each request; the datapath owns all storage.
  ias_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_action (in_tuser),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ias_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // Only one request is in flight: taking a tick, load or clear drops ready.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready &&
     (in_tuser == ACT_TICK || in_tuser == ACT_LOAD || in_tuser == ACT_CLEAR))
    |=> !in_tready)
    else $error("request accepted while another is in progress");

  // The clearing pass must follow reset before any request is taken.
  assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !in_tready)
    else $error("ready raised right after reset");

  // A freshly raised result valid must go back to an accepted tick request.
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready && in_tuser == ACT_TICK, 4))
    else $error("result without a matching tick request");

endmodule

// ----- hw/rtl/ias_ram.sv -----
// ============================================================================
// ias_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ============================================================================
module ias_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- hw/rtl/ias_ctrl.sv -----
// ============================================================================
// ias_ctrl: sequencer controller
// State machine that takes requests and steps the datapath through the
// clearing pass, loads, icon clears and the three reads of a tick.
// ============================================================================
module ias_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  input  logic [ias_pkg::ACTION_W-1:0]  in_action,
  output logic                          in_tready,
  input  ias_pkg::ias_sts_t             sts,
  output ias_pkg::ias_cmd_t             cmd
);
  import ias_pkg::*;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_LOAD,
    ST_CLR,
    ST_T_POS,
    ST_T_CUR,
    ST_T_NXT
  } state_t;

  state_t state_r, state_nxt;
  logic   ready_r, ready_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_INIT: begin
        cmd.init_step = 1'b1;
        if (sts.init_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_tvalid && ready_r) begin
          cmd.capture = 1'b1;
          case (in_action)
            ACT_TICK:  state_nxt = ST_T_POS;
            ACT_LOAD:  state_nxt = ST_LOAD;
            ACT_CLEAR: state_nxt = ST_CLR;
            default:   state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_LOAD: begin
        cmd.load_wr = sts.icon_ok && sts.entry_ok;
        state_nxt   = ST_IDLE;
      end
      ST_CLR: begin
        if (!sts.icon_ok) begin
          state_nxt = ST_IDLE;
        end else begin
          cmd.clear_step = 1'b1;
          if (sts.clear_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_T_POS: begin
        cmd.lat_state = 1'b1;
        state_nxt     = ST_T_CUR;
      end
      ST_T_CUR: begin
        cmd.lat_cur = 1'b1;
        state_nxt   = ST_T_NXT;
      end
      ST_T_NXT: begin
        // Hold here until the output register can take the result.
        if (!sts.out_busy) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_INIT;
      end
    endcase
    ready_nxt = (state_nxt == ST_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
      ready_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ready_r <= ready_nxt;
    end
  end

  assign in_tready = ready_r;

endmodule

// ----- hw/rtl/ias_datapath.sv -----
// ============================================================================
// ias_datapath: sequencer storage and frame logic
// Item registers, the word, position and delay memories, the sweep counter,
// the tick update and the output register.
// ============================================================================
module ias_datapath (
  input  logic                            clk,
  input  logic                            rst_n,
  input  ias_pkg::ias_cmd_t               cmd,
  output ias_pkg::ias_sts_t               sts,
  input  logic [ias_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [ias_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import ias_pkg::*;

  logic [ICON_W-1:0]  icon_r;
  logic [ENTRY_W-1:0] entry_r;
  logic [WORD_W-1:0]  word_r;
  pos_t               pos_r;
  logic [DELAY_W-1:0] cnt_r;
  logic [WORD_W-1:0]  cur_r;
  waddr_t             sweep_r, sweep_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  icon_idx_t          icon_idx, in_idx;
  pos_t               pos_inc;
  pos_t               pos_rdata, pos_new, pos_wdata;
  logic [DELAY_W-1:0] cnt_rdata, cnt_inc, cnt_new, cnt_wdata, delay;
  logic [WORD_W-1:0]  word_rdata, nxt_word, word_wdata;
  waddr_t             word_raddr, word_waddr;
  icon_idx_t          state_waddr;
  logic               past_end, is_static, animate, step;
  logic               word_we, pos_we, cnt_we;

  assign in_idx   = icon_index(in_tdata[ICON_LSB +: ICON_W]);
  assign icon_idx = icon_index(icon_r);
  assign pos_inc  = pos_r + POS_AW'(1);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      icon_r  <= in_tdata[ICON_LSB +: ICON_W];
      entry_r <= in_tdata[ENTRY_LSB +: ENTRY_W];
      word_r  <= in_tdata[WORD_LSB +: WORD_W];
    end
    if (cmd.lat_state) begin
      pos_r <= pos_rdata;
      cnt_r <= cnt_rdata;
    end
    if (cmd.lat_cur) begin
      cur_r <= word_rdata;
    end
  end

  // Frame decision once the word after the current one is on the read port.
  always_comb begin
    past_end  = ({1'b0, pos_r} + (POS_AW + 1)'(1)) >= SEQ_LEN_V;
    nxt_word  = past_end ? WORD_END : word_rdata;
    is_static = (cur_r == WORD_STATIC) && (nxt_word == WORD_STATIC_NEXT);
    animate   = sts.icon_ok && !is_static;
    delay     = DELAY_W'(cur_r & DELAY_MASK);
    cnt_inc   = (cnt_r == DELAY_MAX) ? DELAY_MAX : cnt_r + DELAY_W'(1);
    step      = (cnt_inc >= delay);
    cnt_new   = step ? '0 : cnt_inc;
    if (!step) begin
      pos_new = pos_r;
    end else if (nxt_word == WORD_END) begin
      pos_new = '0;
    end else begin
      pos_new = pos_inc;
    end
  end

  // Memory port muxing.
  always_comb begin
    word_raddr  = cmd.lat_state ? {icon_idx, pos_rdata} : {icon_idx, pos_inc};
    word_we     = cmd.init_step || cmd.clear_step || cmd.load_wr;
    word_wdata  = cmd.load_wr ? word_r : WORD_END;
    if (cmd.init_step) begin
      word_waddr = sweep_r;
    end else if (cmd.clear_step) begin
      word_waddr = {icon_idx, sweep_r[POS_AW-1:0]};
    end else begin
      word_waddr = {icon_idx, entry_pos(entry_r)};
    end

    state_waddr = cmd.init_step ? sweep_r[WADDR_W-1 -: ICON_AW] : icon_idx;
    pos_we      = cmd.init_step || cmd.clear_step || cmd.load_wr ||
                  (cmd.finish && animate);
    pos_wdata   = cmd.finish ? pos_new : '0;
    cnt_we      = cmd.init_step || (cmd.finish && animate);
    cnt_wdata   = cmd.finish ? cnt_new : '0;
  end

  ias_ram #(.WIDTH(WORD_W), .DEPTH(2 ** WADDR_W)) u_word_ram (
    .clk   (clk),
    .we    (word_we),
    .waddr (word_waddr),
    .wdata (word_wdata),
    .raddr (word_raddr),
    .rdata (word_rdata)
  );

  ias_ram #(.WIDTH(POS_AW), .DEPTH(2 ** ICON_AW)) u_pos_ram (
    .clk   (clk),
    .we    (pos_we),
    .waddr (state_waddr),
    .wdata (pos_wdata),
    .raddr (cmd.capture ? in_idx : icon_idx),
    .rdata (pos_rdata)
  );

  ias_ram #(.WIDTH(DELAY_W), .DEPTH(2 ** ICON_AW)) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (state_waddr),
    .wdata (cnt_wdata),
    .raddr (cmd.capture ? in_idx : icon_idx),
    .rdata (cnt_rdata)
  );

  // Sweep counter: the whole address during the reset pass, only the word
  // position during an icon clear, so it rests at zero between uses.
  always_comb begin
    sweep_nxt = sweep_r;
    if (cmd.init_step) begin
      sweep_nxt = sweep_r + WADDR_W'(1);
    end else if (cmd.clear_step) begin
      sweep_nxt[POS_AW-1:0] = sweep_r[POS_AW-1:0] + POS_AW'(1);
    end
  end

  // Output register.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = '0;
      if (animate) begin
        out_data_nxt[PAL_W-1:0]         = cur_r[SW_PAL_LSB +: PAL_W];
        out_data_nxt[PAL_W +: BMP_W]    = cur_r[SW_BMP_LSB +: BMP_W];
        out_data_nxt[PAL_W + BMP_W]     = cur_r[SW_FLIPH];
        out_data_nxt[PAL_W + BMP_W + 1] = cur_r[SW_FLIPV];
      end
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      sweep_r     <= sweep_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign sts.init_last  = &sweep_r;
  assign sts.clear_last = &sweep_r[POS_AW-1:0];
  assign sts.icon_ok    = 32'(icon_r) < 32'(ICON_COUNT);
  assign sts.entry_ok   = 32'(entry_r) < 32'(SEQ_LENGTH);
  assign sts.out_busy   = out_valid_r && !out_tready;

endmodule

// ----- verif/icon_animation_sequencer_unit_tb.sv -----
`timescale 1ns / 100ps
// ============================================================================
// icon_animation_sequencer_unit_tb: self-checking bench for the icon player
// Drives tick, load, clear and unused requests into the request stream and
// checks every frame on the result stream against an in-bench model of the
// per-icon sequence memories, play positions and delay counters.
// ============================================================================
module icon_animation_sequencer_unit_tb;
  import ias_pkg::*;

  localparam int CLK_PERIOD   = 10;
  localparam int RESET_CYCLES = 8;
  // Longest quiet stretch allowed: covers the clearing pass after reset,
  // the long result hold-off and a full icon clear, several times over.
  localparam int STALL_LIMIT  = 20000;
  localparam int ITEM_TARGET  = 1600;
  // From this many requests on, neither side idles any more.
  localparam int CALM_FROM    = 1450;
  // The receiver holds off once, after this many requests.
  localparam int HOLD_AT      = 400;
  localparam int HOLD_CYCLES  = 300;
  // Long enough for a full icon clear, with a little more for any late frame.
  localparam int DRAIN_CYCLES = 80;

  // The action code that the block must ignore.
  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [ICON_W-1:0]   icon;
    logic [ENTRY_W-1:0]  entry;
    logic [WORD_W-1:0]   word;
  } request_t;

  typedef struct packed {
    logic [PAL_W-1:0]  palette;
    logic [BMP_W-1:0]  bitmap;
    logic [FLIP_W-1:0] flip;
  } frame_t;

  typedef struct packed {
    request_t req;
    logic     typed;   // frame below is the known answer
    frame_t   frame;
  } directed_row_t;

  localparam int DIRECTED_ROWS = 20;

  // Directed requests. Rows marked typed carry an answer that follows
  // directly from the reset state or from an extreme word; the others are
  // checked against the model.
  directed_row_t directed_rows [DIRECTED_ROWS] = '{
    // Fresh icons play an all-zero word.
    '{'{ACT_TICK,   6'd0,  6'd0,  16'h0000}, 1'b1, '{3'd0, 3'd0, 2'd0}},
    '{'{ACT_TICK,   6'd63, 6'd0,  16'h0000}, 1'b1, '{3'd0, 3'd0, 2'd0}},
    // Highest icon and entry, all-ones word.
    '{'{ACT_LOAD,   6'd63, 6'd63, 16'hFFFF}, 1'b0, '{3'd0, 3'd0, 2'd0}},
    '{'{ACT_LOAD,   6'd63, 6'd0,  16'hFFFF}, 1'b0, '{3'd0, 3'd0, 2'd0}},
    '{'{ACT_TICK,   6'd63, 6'd0,  16'h0000}, 1'b1, '{3'd7, 3'd7, 2'd3}},
    // A clear wipes the icon back to zeros.
    '{'{ACT_CLEAR,  6'd63, 6'd0,  16'h0000}, 1'b0, '{3'd0, 3'd0, 2'd0}},
    '{'{ACT_TICK,   6'd63, 6'd0,  16'h0000}, 1'b1, '{3'd0, 3'd0, 2'd0}},
    // The not-animated marker pair reports zeros.
    '{'{ACT_LOAD,   6'd1,  6'd0,  WORD_STATIC}, 1'b0, '{3'd0, 3'd0, 2'd0}},
    '{'{ACT_LOAD,   6'd1,  6'd1,  WORD_STATIC_NEXT}, 1'b0, '{3'd0, 3'd0, 2'd0}},
    '{'{ACT_TICK,   6'd1,  6'd0,  16'h0000}, 1'b1, '{3'd0, 3'd0, 2'd0}},
    // Break the pair: the same first word now plays normally.
    '{'{ACT_LOAD,   6'd1,  6'd1,  16'h0101}, 1'b0, '{3'd0, 3'd0, 2'd0}},
    '{'{ACT_TICK,   6'd1,  6'd0,  16'h0000}, 1'b0, '{3'd0, 3'd0, 2'd0}},
    '{'{ACT_TICK,   6'd1,  6'd0,  16'h0000}, 1'b0, '{3'd0, 3'd0, 2'd0}},
    // Zero delay bytes advance on every tick; flips in both directions.
    '{'{ACT_LOAD,   6'd2,  6'd0,  16'h4800}, 1'b0, '{3'd0, 3'd0, 2'd0}},
    '{'{ACT_LOAD,   6'd2,  6'd1,  16'h8300}, 1'b0, '{3'd0, 3'd0, 2'd0}},
    '{'{ACT_TICK,   6'd2,  6'd0,  16'h0000}, 1'b0, '{3'd0, 3'd0, 2'd0}},
    '{'{ACT_TICK,   6'd2,  6'd0,  16'h0000}, 1'b0, '{3'd0, 3'd0, 2'd0}},
    '{'{ACT_TICK,   6'd2,  6'd0,  16'h0000}, 1'b0, '{3'd0, 3'd0, 2'd0}},
    // The unused action must leave everything alone.
    '{'{ACT_UNUSED, 6'd0,  6'd63, 16'hFFFF}, 1'b0, '{3'd0, 3'd0, 2'd0}},
    '{'{ACT_TICK,   6'd0,  6'd0,  16'h0000}, 1'b1, '{3'd0, 3'd0, 2'd0}}
  };

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic [ACTION_W-1:0]    in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;

  // Model state: sequence words, play position and delay count per icon.
  logic [WORD_W-1:0] seq_mem [ICON_COUNT][SEQ_LENGTH];
  int                play_pos   [ICON_COUNT];
  int                hold_count [ICON_COUNT];

  // Frames still owed by the block, oldest first.
  frame_t pending_frames [$];

  int  errors;
  int  requests_sent;
  int  ticks_sent;
  int  loads_sent;
  int  clears_sent;
  int  frames_checked;
  int  full_sequences;
  int  recent_icon;
  bit  calm;       // last part of the run: no idling on either side
  bit  hold_req;   // sender asks the receiver for one long hold-off
  bit  hold_done;

  icon_animation_sequencer_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial clk = 1'b0;
  always #(CLK_PERIOD / 2) clk = ~clk;

  // A word position past the end of the sequence reads as an end word.
  function automatic logic [WORD_W-1:0] word_at(input int icon, input int pos);
    if (pos >= SEQ_LENGTH) return WORD_END;
    return seq_mem[icon][pos];
  endfunction

  // Applies one request to the model state and works out the frame that it
  // produces. Only tick requests produce a frame.
  task automatic frame_for_request(input request_t r, output bit emits,
                                   output frame_t f);
    logic [WORD_W-1:0] cur;
    logic [WORD_W-1:0] nxt;
    int                pos;
    int                cnt;
    emits = 1'b0;
    f     = '0;
    case (r.action)
      ACT_LOAD: begin
        seq_mem[r.icon][r.entry] = r.word;
        play_pos[r.icon] = 0;
      end
      ACT_CLEAR: begin
        for (int i = 0; i < SEQ_LENGTH; i++) seq_mem[r.icon][i] = WORD_END;
        play_pos[r.icon] = 0;
      end
      ACT_TICK: begin
        emits = 1'b1;
        pos = play_pos[r.icon];
        cur = word_at(r.icon, pos);
        nxt = word_at(r.icon, pos + 1);
        // The marker pair means a still icon: zeros, and no state change.
        if (!(cur == WORD_STATIC && nxt == WORD_STATIC_NEXT)) begin
          f.palette = cur[SW_PAL_LSB +: PAL_W];
          f.bitmap  = cur[SW_BMP_LSB +: BMP_W];
          f.flip    = {cur[SW_FLIPV], cur[SW_FLIPH]};
          cnt = hold_count[r.icon] + 1;
          if (cnt > int'(DELAY_MAX)) cnt = int'(DELAY_MAX);
          if (cnt >= int'(cur & DELAY_MASK)) begin
            cnt = 0;
            pos = pos + 1;
            if (word_at(r.icon, pos) == WORD_END) pos = 0;
            play_pos[r.icon] = pos;
          end
          hold_count[r.icon] = cnt;
        end
      end
      default: ;
    endcase
  endtask

  // Offers one request, possibly after a burst of idle cycles, and waits for
  // the handshake. The expected frame is queued at acceptance.
  task automatic send_request(input request_t r, input bit typed,
                              input frame_t typed_frame);
    logic [IN_TDATA_W-1:0] data;
    bit                    emits;
    frame_t                f;
    data = '0;
    data[ICON_LSB  +: ICON_W]  = r.icon;
    data[ENTRY_LSB +: ENTRY_W] = r.entry;
    data[WORD_LSB  +: WORD_W]  = r.word;
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= r.action;
    in_tdata  <= data;
    do @(posedge clk); while (!in_tready);
    frame_for_request(r, emits, f);
    if (emits) pending_frames.push_back(typed ? typed_frame : f);
    case (r.action)
      ACT_TICK:  ticks_sent++;
      ACT_LOAD:  loads_sent++;
      ACT_CLEAR: clears_sent++;
      default:   ;
    endcase
    if (r.action != ACT_UNUSED) requests_sent++;
    if (!hold_done && requests_sent >= HOLD_AT) begin
      hold_req  = 1'b1;
      hold_done = 1'b1;
    end
    if (requests_sent >= CALM_FROM) calm = 1'b1;
  endtask

  // Plain request without a typed answer.
  task automatic send_plain(input logic [ACTION_W-1:0] action, input int icon,
                            input int entry, input logic [WORD_W-1:0] word);
    send_request('{action, ICON_W'(icon), ENTRY_W'(entry), word}, 1'b0, '0);
  endtask

  // Well-formed play: optionally clear an icon, load a sequence into it, then
  // tick through it. Most sequences are short with small delays so that the
  // position moves a lot; now and then a full-length one walks to the last
  // word, where the word after it reads as the end.
  task automatic play_sequence();
    int                icon;
    int                len;
    int                ticks;
    bit                full;
    bit                marker_next;
    logic [WORD_W-1:0] w;
    icon = $urandom_range(0, ICON_COUNT - 1);
    recent_icon = icon;
    if ($urandom_range(0, 9) < 7) send_plain(ACT_CLEAR, icon, 0, 16'h0000);
    full = ($urandom_range(0, 11) == 0);
    len  = full ? $urandom_range(56, SEQ_LENGTH) : $urandom_range(1, 8);
    if (full) full_sequences++;
    marker_next = 1'b0;
    for (int e = 0; e < len; e++) begin
      w = WORD_W'($urandom);
      if ($urandom_range(0, 7) != 0) w[DELAY_W-1:0] = DELAY_W'($urandom_range(0, 3));
      if (!full && $urandom_range(0, 11) == 0) w = WORD_END;
      if (marker_next) begin
        w = WORD_STATIC_NEXT;
        marker_next = 1'b0;
      end else if (e + 1 < len && $urandom_range(0, 15) == 0) begin
        w = WORD_STATIC;
        marker_next = 1'b1;
      end
      // Full-length sequences must not end early on a zero word.
      if (full && w == WORD_END) w[SW_BMP_LSB] = 1'b1;
      send_plain(ACT_LOAD, icon, e, w);
    end
    ticks = full ? $urandom_range(70, 200) : $urandom_range(1, 4 * len + 6);
    for (int t = 0; t < ticks && requests_sent < ITEM_TARGET; t++) begin
      if ($urandom_range(0, 7) == 0)
        send_plain(ACT_TICK, $urandom_range(0, ICON_COUNT - 1), 0, WORD_W'($urandom));
      else if ($urandom_range(0, 39) == 0)
        // A reload in mid-play rewinds the position.
        send_plain(ACT_LOAD, icon, $urandom_range(0, len - 1), WORD_W'($urandom));
      else
        send_plain(ACT_TICK, icon, $urandom_range(0, SEQ_LENGTH - 1), 16'h0000);
    end
  endtask

  // Stimulus: reset, the directed rows, then random play until the target.
  initial begin : stimulus
    int pick;
    int n;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    in_tuser       = ACT_TICK;
    rst_n          = 1'b0;
    errors         = 0;
    requests_sent  = 0;
    ticks_sent     = 0;
    loads_sent     = 0;
    clears_sent    = 0;
    frames_checked = 0;
    full_sequences = 0;
    recent_icon    = 0;
    calm           = 1'b0;
    hold_req       = 1'b0;
    hold_done      = 1'b0;
    for (int i = 0; i < ICON_COUNT; i++) begin
      play_pos[i]   = 0;
      hold_count[i] = 0;
      for (int j = 0; j < SEQ_LENGTH; j++) seq_mem[i][j] = WORD_END;
    end
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // The block clears its memories after reset; the first handshake simply
    // waits for that to finish.
    for (int i = 0; i < DIRECTED_ROWS; i++)
      send_request(directed_rows[i].req, directed_rows[i].typed,
                   directed_rows[i].frame);

    while (requests_sent < ITEM_TARGET) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        play_sequence();
      end else if (pick < 85) begin
        n = $urandom_range(1, 8);
        for (int k = 0; k < n; k++)
          send_plain(ACT_TICK,
                     ($urandom_range(0, 1) == 0) ? recent_icon
                                                 : $urandom_range(0, ICON_COUNT - 1),
                     0, 16'h0000);
      end else begin
        // Noise: any action, every field fully random.
        n = $urandom_range(1, 4);
        for (int k = 0; k < n; k++)
          send_plain(ACTION_W'($urandom_range(0, 3)), $urandom_range(0, ICON_COUNT - 1),
                     $urandom_range(0, SEQ_LENGTH - 1), WORD_W'($urandom));
      end
    end
    in_tvalid <= 1'b0;

    // Wait out the remaining frames, then a few more cycles for strays.
    while (pending_frames.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d requests: %0d ticks, %0d loads, %0d clears.",
             requests_sent, ticks_sent, loads_sent, clears_sent);
    $display("%0d frames checked, %0d full-length sequences played, %0d errors.",
             frames_checked, full_sequences, errors);
    if (errors == 0) begin
      $display("icon_animation_sequencer_unit_tb passed");
    end else begin
      $display("icon_animation_sequencer_unit_tb failed");
    end
    $finish;
  end

  // Result side: random ready bursts, one long hold-off on request so that
  // the block fills up and stalls its input, and steady ready at the end.
  initial begin : receiver
    out_tready = 1'b0;
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (calm) begin
        out_tready <= 1'b1;
        @(posedge clk);
      end else if ($urandom_range(0, 2) != 0) begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end else begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end
    end
  end

  // Every accepted frame is compared with the oldest one owed.
  always @(posedge clk) begin : frame_checker
    frame_t got;
    frame_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.palette = out_tdata[0 +: PAL_W];
      got.bitmap  = out_tdata[PAL_W +: BMP_W];
      got.flip    = out_tdata[PAL_W + BMP_W +: FLIP_W];
      if (pending_frames.size() == 0) begin
        $error("frame with none expected: palette_index %0d bitmap_index %0d flip_mode %0d",
               got.palette, got.bitmap, got.flip);
        errors++;
      end else begin
        want = pending_frames.pop_front();
        frames_checked++;
        if (got.palette !== want.palette) begin
          $error("palette_index: expected %0d, got %0d", want.palette, got.palette);
          errors++;
        end
        if (got.bitmap !== want.bitmap) begin
          $error("bitmap_index: expected %0d, got %0d", want.bitmap, got.bitmap);
          errors++;
        end
        if (got.flip !== want.flip) begin
          $error("flip_mode: expected %0d, got %0d", want.flip, got.flip);
          errors++;
        end
      end
    end
  end

  // Watchdog: ends the run when neither stream moves for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet = 0;
      else quiet++;
    end
    $display("Timeout: no handshake for %0d cycles, %0d frames still owed.",
             STALL_LIMIT, pending_frames.size());
    $display("icon_animation_sequencer_unit_tb failed");
    $finish;
  end

endmodule
